// File: hdl/kway_merge_min_heap_defines.svh
// Assertion macros for the k-way merge heap block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef KWAY_MERGE_MIN_HEAP_DEFINES_SVH
`define KWAY_MERGE_MIN_HEAP_DEFINES_SVH
`ifndef SYNTH
`define KWM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kway_merge_min_heap: assertion failed");
`define KWM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("kway_merge_min_heap: assertion failed");
`else
`define KWM_ASSERT(label, clk, rst, prop)
`define KWM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: hdl/kwm_pkg.sv
// Shared types and constants of the k-way merge heap block.
// No dependencies; imported by the top level.
`default_nettype none
package kwm_pkg;

  localparam int VAL_W  = 32;  // element and result value width
  localparam int SRC_W  = 3;   // stream number width on the ports
  localparam int CFG_W  = 4;   // width of the stream count register
  localparam int LCNT_W = 4;   // load counter, holds up to the stream count

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [SRC_W-1:0]        source;
  } heap_entry_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FETCH = 10'b00_0000_0010,
    S_GRAB  = 10'b00_0000_0100,
    S_LEFT  = 10'b00_0000_1000,
    S_RIGHT = 10'b00_0001_0000,
    S_DEC   = 10'b00_0010_0000,
    S_NEXT  = 10'b00_0100_0000,
    S_ROOT  = 10'b00_1000_0000,
    S_ROOTW = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

endpackage
`default_nettype wire

// File: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the heap store of the merge block.
`default_nettype none
module kwm_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/kway_merge_min_heap.sv
// K-way merge of sorted signed streams through a binary min-heap of stream heads.
// Depends on kwm_pkg, kwm_ram and kway_merge_min_heap_defines.svh.
//
// Write lists_in_use while idle, then send one load transaction per stream in
// stream order (stream_ended marks an empty stream). The last load builds the
// heap and returns the smallest head; every following transaction refills the
// stream named by the last source_stream, and a refill naming another stream
// is dropped without a result. The heap lives in one RAM with a registered
// read, so every sift level reads the left child, reads the right child, then
// compares and writes back. A refill holds the input while it sifts down from
// the root; when the stream has ended, the last entry moves to the root first.
// The build sifts each inner node in turn, from the last one down to the root,
// fetching each node before its levels. No clearing pass follows reset. A result
// waits in an output register while the next transaction is already taken.
`default_nettype none
`include "kway_merge_min_heap_defines.svh"
module kway_merge_min_heap
  import kwm_pkg::*;
#(
  parameter int MAX_STREAMS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        lists_in_use,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire logic [SRC_W-1:0]        list_index,
  input  wire logic signed [VAL_W-1:0] element_value,
  input  wire logic                    stream_ended,
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output logic signed [VAL_W-1:0]      merged_value,
  output logic [SRC_W-1:0]             source_stream,
  output logic                         has_value,
  output logic                         merge_done
);

  localparam int ADDR_W  = $clog2(MAX_STREAMS);
  localparam int CNT_W   = $clog2(MAX_STREAMS + 1);
  localparam int IX_W    = ADDR_W + 2;
  localparam int ENTRY_W = $bits(heap_entry_t);

  state_t               state;
  logic                 merging;
  logic [CNT_W-1:0]     heap_count;
  logic [LCNT_W-1:0]    loaded_count;
  logic [CFG_W-1:0]     lists_reg;
  logic [ADDR_W-1:0]    node;
  logic [ADDR_W-1:0]    pnode;
  logic                 heapify;
  heap_entry_t          cur;
  heap_entry_t          best;
  logic                 best_is_child;
  logic                 has_right;
  logic [SRC_W-1:0]     ans_src;
  logic signed [VAL_W-1:0] res_value;
  logic [SRC_W-1:0]     res_src;
  logic                 res_has;
  logic                 res_done;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  heap_entry_t          rd;

  logic                 item_fire;
  logic [CFG_W-1:0]     k;
  logic                 load_store;
  logic [LCNT_W-1:0]    lc_next;
  logic [CNT_W-1:0]     hc_next;
  logic [CNT_W-1:0]     p0_full;
  logic [IX_W-1:0]      left_ix;
  logic [IX_W-1:0]      right_ix;
  logic [IX_W-1:0]      hc_ix;
  logic                 has_left;
  logic                 has_r;
  logic                 left_less;
  logic                 right_wins;
  logic                 moved;
  heap_entry_t          child;

  kwm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_STREAMS)) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd         = heap_entry_t'(ram_rdata);
  assign cfg_ready  = !rst;
  assign item_ready = (state == S_IDLE) && !rst;
  assign item_fire  = item_valid && item_ready;

  // Zero streams act as one; more than the heap holds act as a full heap.
  always_comb begin
    if (lists_reg == '0) begin
      k = CFG_W'(1);
    end else if ((MAX_STREAMS < (1 << CFG_W)) && (lists_reg > CFG_W'(MAX_STREAMS))) begin
      k = CFG_W'(MAX_STREAMS);
    end else begin
      k = lists_reg;
    end
  end

  always_comb begin
    load_store = (loaded_count < k) && !stream_ended
                 && (heap_count < CNT_W'(MAX_STREAMS));
    lc_next = loaded_count;
    hc_next = heap_count;
    if (loaded_count < k) begin
      lc_next = loaded_count + LCNT_W'(1);
      if (load_store) begin
        hc_next = heap_count + CNT_W'(1);
      end
    end
    p0_full = CNT_W'(hc_next - CNT_W'(2)) >> 1;
  end

  always_comb begin
    left_ix    = IX_W'({node, 1'b1});
    right_ix   = left_ix + IX_W'(1);
    hc_ix      = IX_W'(heap_count);
    has_left   = left_ix < hc_ix;
    has_r      = right_ix < hc_ix;
    left_less  = rd.value < cur.value;
    // A right child replaces the pick so far only when strictly smaller.
    right_wins = has_right && (rd.value < best.value);
    child      = right_wins ? rd : best;
    moved      = right_wins || best_is_child;
  end

  // Each state touches at most one RAM address per port; a write and the read of
  // the same cycle may name the same entry, and the read then returns the old one.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = cur;
    ram_raddr = node;
    case (state)
      S_IDLE: begin
        if (item_fire && !merging && load_store) begin
          ram_we    = 1'b1;
          ram_waddr = heap_count[ADDR_W-1:0];
          ram_wdata = heap_entry_t'({element_value, loaded_count[SRC_W-1:0]});
        end
        ram_raddr = ADDR_W'(heap_count - CNT_W'(1));
      end
      S_FETCH: ram_raddr = node;
      S_LEFT: begin
        if (has_left) begin
          ram_raddr = left_ix[ADDR_W-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_RIGHT: ram_raddr = right_ix[ADDR_W-1:0];
      S_DEC: begin
        ram_we    = 1'b1;
        ram_wdata = moved ? child : cur;
      end
      S_ROOT: ram_raddr = '0;
      default: ram_raddr = node;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      merging      <= 1'b0;
      heap_count   <= '0;
      loaded_count <= '0;
      lists_reg    <= CFG_W'(8);
      result_valid <= 1'b0;
      heapify      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lists_reg <= lists_in_use;
      end
      if (state == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_fire) begin
            if (!merging) begin
              if (lc_next < k) begin
                loaded_count <= lc_next;
                heap_count   <= hc_next;
              end else if (hc_next >= CNT_W'(2)) begin
                loaded_count <= lc_next;
                heap_count   <= hc_next;
                merging      <= 1'b1;
                heapify      <= 1'b1;
                node         <= p0_full[ADDR_W-1:0];
                pnode        <= p0_full[ADDR_W-1:0];
                state        <= S_FETCH;
              end else if (hc_next == CNT_W'(1)) begin
                loaded_count <= lc_next;
                heap_count   <= hc_next;
                merging      <= 1'b1;
                state        <= S_ROOT;
              end else begin
                res_done     <= 1'b1;
                heap_count   <= '0;
                loaded_count <= '0;
                state        <= S_EMIT;
              end
            end else if (heap_count == '0) begin
              res_done     <= 1'b1;
              merging      <= 1'b0;
              loaded_count <= '0;
              state        <= S_EMIT;
            end else if (list_index == ans_src) begin
              heapify <= 1'b0;
              node    <= '0;
              if (stream_ended) begin
                heap_count <= heap_count - CNT_W'(1);
                if (heap_count == CNT_W'(1)) begin
                  res_done     <= 1'b1;
                  merging      <= 1'b0;
                  loaded_count <= '0;
                  state        <= S_EMIT;
                end else begin
                  // The last entry is being read and moves to the root.
                  state <= S_GRAB;
                end
              end else begin
                cur.value  <= element_value;
                cur.source <= ans_src;
                state      <= S_LEFT;
              end
            end
          end
        end
        S_FETCH: state <= S_GRAB;
        S_GRAB: begin
          cur   <= rd;
          state <= S_LEFT;
        end
        S_LEFT: begin
          state <= has_left ? S_RIGHT : S_NEXT;
        end
        S_RIGHT: begin
          best_is_child <= left_less;
          best          <= left_less ? rd : cur;
          has_right     <= has_r;
          state         <= S_DEC;
        end
        S_DEC: begin
          if (moved) begin
            node  <= right_wins ? right_ix[ADDR_W-1:0] : left_ix[ADDR_W-1:0];
            state <= S_LEFT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (heapify && (pnode != '0)) begin
            pnode <= pnode - ADDR_W'(1);
            node  <= pnode - ADDR_W'(1);
            state <= S_FETCH;
          end else begin
            heapify <= 1'b0;
            state   <= S_ROOT;
          end
        end
        S_ROOT: state <= S_ROOTW;
        S_ROOTW: begin
          res_value <= rd.value;
          res_src   <= rd.source;
          ans_src   <= rd.source;
          res_has   <= 1'b1;
          res_done  <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A done result carries zero payload.
      if (state == S_IDLE && item_fire) begin
        res_value <= '0;
        res_src   <= '0;
        res_has   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!result_valid || result_ready)) begin
      merged_value  <= res_value;
      source_stream <= res_src;
      has_value     <= res_has;
      merge_done    <= res_done;
    end
  end

  `KWM_ASSERT(a_count_bound, clk, rst, heap_count <= CNT_W'(MAX_STREAMS))
  `KWM_ASSERT(a_done_no_value, clk, rst, (result_valid && merge_done) |-> !has_value)
  `KWM_ASSERT(a_idle_write_is_load, clk, rst, (ram_we && item_ready) |-> (item_fire && !merging))
  `KWM_ASSERT(a_merge_has_heads, clk, rst, merging |-> (heap_count != '0))

endmodule
`default_nettype wire

// File: tb/tb_kway_merge_min_heap.sv
`timescale 1ns / 1ps
// Self-checking testbench for the k-way merge heap: a mirror of the heap predicts every result.
// Depends on kwm_pkg and the kway_merge_min_heap RTL only.
module tb_kway_merge_min_heap;
  import kwm_pkg::*;

  localparam int MAX_K = 8;
  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  typedef enum int unsigned {
    SORTED_WIDE,
    TIE_HEAVY,
    UNSORTED
  } value_mode_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [SRC_W-1:0]        stream;
    logic                    has_value;
    logic                    done;
  } merge_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        lists_in_use = '0;
  logic                    item_valid = 1'b0;
  logic                    item_ready;
  logic [SRC_W-1:0]        list_index = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    stream_ended = 1'b0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [VAL_W-1:0] merged_value;
  logic [SRC_W-1:0]        source_stream;
  logic                    has_value;
  logic                    merge_done;

  // Mirror of the block: heap of stream heads, counts and the stream count register.
  heap_entry_t      heap_mirror [MAX_K];
  int unsigned      heap_n = 0;
  int unsigned      loads_seen = 0;
  bit               merging = 1'b0;
  logic [CFG_W-1:0] stream_cfg = 4'd8;
  merge_result_t    expected_q [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_requests = 0;
  int unsigned cycle_count = 0;

  kway_merge_min_heap u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .lists_in_use (lists_in_use),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .list_index   (list_index),
    .element_value(element_value),
    .stream_ended (stream_ended),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .merged_value (merged_value),
    .source_stream(source_stream),
    .has_value    (has_value),
    .merge_done   (merge_done)
  );

  always #2 clk = ~clk;

  function automatic int unsigned active_streams();
    if (stream_cfg == 0) return 1;
    if (stream_cfg > MAX_K) return MAX_K;
    return 32'(stream_cfg);
  endfunction

  function automatic void clear_run();
    heap_n = 0;
    loads_seen = 0;
    merging = 1'b0;
  endfunction

  // Ties keep the parent, and the right child only wins when strictly below the pick.
  function automatic void heap_settle(int unsigned node);
    int unsigned pick;
    int unsigned left;
    int unsigned right;
    bit settled;
    heap_entry_t held;
    settled = 1'b0;
    while (!settled && node < heap_n) begin
      pick = node;
      left = 2 * node + 1;
      right = left + 1;
      if (left < heap_n && heap_mirror[left].value < heap_mirror[pick].value) pick = left;
      if (right < heap_n && heap_mirror[right].value < heap_mirror[pick].value) pick = right;
      if (pick == node) begin
        settled = 1'b1;
      end else begin
        held = heap_mirror[pick];
        heap_mirror[pick] = heap_mirror[node];
        heap_mirror[node] = held;
        node = pick;
      end
    end
  endfunction

  function automatic void push_answer();
    merge_result_t r;
    if (heap_n == 0) begin
      r.value = '0;
      r.stream = '0;
      r.has_value = 1'b0;
      r.done = 1'b1;
      clear_run();
    end else begin
      r.value = heap_mirror[0].value;
      r.stream = heap_mirror[0].source;
      r.has_value = 1'b1;
      r.done = 1'b0;
    end
    expected_q.push_back(r);
  endfunction

  function automatic void predict_merge(logic [SRC_W-1:0] idx, logic signed [VAL_W-1:0] val,
                                        logic ended);
    int unsigned k;
    int p;
    k = active_streams();
    if (!merging) begin
      // Loads take their stream number from the load count, not from list_index.
      if (loads_seen < k) begin
        if (!ended && heap_n < MAX_K) begin
          heap_mirror[heap_n].value = val;
          heap_mirror[heap_n].source = loads_seen[SRC_W-1:0];
          heap_n++;
        end
        loads_seen++;
      end
      if (loads_seen < k) return;
      if (heap_n >= 2) begin
        for (p = int'((heap_n - 2) / 2); p >= 0; p--) heap_settle(p);
      end
      merging = 1'b1;
      push_answer();
      return;
    end
    if (heap_n == 0) begin
      clear_run();
      push_answer();
      return;
    end
    if (idx != heap_mirror[0].source) return;
    if (ended) begin
      heap_n--;
      if (heap_n == 0) begin
        push_answer();
        return;
      end
      heap_mirror[0] = heap_mirror[heap_n];
    end else begin
      heap_mirror[0].value = val;
    end
    heap_settle(0);
    push_answer();
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // The sender offers transactions in bursts; the mirror advances when one is accepted.
  task automatic send_item(input logic [SRC_W-1:0] idx, input logic signed [VAL_W-1:0] val,
                           input logic ended);
    int unsigned gap;
    int unsigned r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      r = $urandom_range(0, 9);
      if (r < 3) gap = 0;
      else if (r < 9) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 30);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    list_index <= idx;
    element_value <= val;
    stream_ended <= ended;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_merge(idx, val, ended);
    items_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] streams);
    cfg_valid <= 1'b1;
    lists_in_use <= streams;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    stream_cfg = streams;
  endtask

  function automatic logic signed [VAL_W-1:0] first_element(input value_mode_t mode);
    if ($urandom_range(0, 15) == 0) return VAL_MIN;
    if (mode == TIE_HEAVY) return $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] next_element(input value_mode_t mode,
                                                            input logic signed [VAL_W-1:0] prev);
    longint sum;
    int unsigned step;
    if (mode == UNSORTED) return $urandom;
    step = (mode == TIE_HEAVY) ? $urandom_range(0, 1) : $urandom_range(0, 1 << 20);
    sum = longint'(prev) + longint'(step);
    if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
    return sum[VAL_W-1:0];
  endfunction

  // One complete merge with the current stream count, ending on the done result.
  task automatic merge_one_run(input value_mode_t mode);
    int unsigned left_in_stream [MAX_K];
    logic signed [VAL_W-1:0] head [MAX_K];
    int unsigned k;
    int unsigned s;
    logic [SRC_W-1:0] want;
    logic [SRC_W-1:0] flip;
    k = active_streams();
    for (s = 0; s < k; s++) begin
      left_in_stream[s] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      head[s] = first_element(mode);
      send_item(SRC_W'($urandom_range(0, 7)), head[s], left_in_stream[s] == 0);
      if (left_in_stream[s] > 0) left_in_stream[s]--;
    end
    while (merging) begin
      want = heap_mirror[0].source;
      if ($urandom_range(0, 11) == 0) begin
        // A refill for some other stream must be dropped.
        flip = SRC_W'($urandom_range(1, 7));
        send_item(want ^ flip, $urandom, 1'($urandom_range(0, 1)));
      end else if (left_in_stream[want] == 0 || $urandom_range(0, 49) == 0) begin
        send_item(want, $urandom, 1'b1);
      end else begin
        head[want] = next_element(mode, head[want]);
        left_in_stream[want]--;
        send_item(want, head[want], 1'b0);
      end
    end
  endtask

  task automatic test_single_stream();
    wait_idle();
    write_cfg(4'd1);
    send_item(3'd7, 32'sh1234, 1'b1);
    wait_idle();
    // A count of zero behaves as one stream.
    write_cfg(4'd0);
    send_item(3'd3, VAL_MIN, 1'b0);
    send_item(3'd7, 32'sd0, 1'b0);
    send_item(3'd0, VAL_MAX, 1'b0);
    send_item(3'd0, -32'sd1, 1'b1);
  endtask

  task automatic test_mid_load_shrink();
    wait_idle();
    write_cfg(4'd15);
    send_item(3'd7, -32'sd100, 1'b0);
    send_item(3'd2, 32'sd0, 1'b1);
    send_item(3'd0, -32'sd100, 1'b0);
    wait_idle();
    // The next load finds the count already reached: it is dropped and closes the load phase.
    write_cfg(4'd2);
    send_item(3'd5, 32'sd999, 1'b0);
    while (merging) send_item(heap_mirror[0].source, 32'sd0, 1'b1);
  endtask

  task automatic test_tie_order();
    wait_idle();
    write_cfg(4'd3);
    repeat (3) send_item(SRC_W'($urandom_range(0, 7)), 32'sd5, 1'b0);
    send_item(heap_mirror[0].source, 32'sd5, 1'b0);
    send_item(heap_mirror[0].source, 32'sd6, 1'b0);
    while (merging) send_item(heap_mirror[0].source, 32'sd0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    write_cfg(4'd8);
    stall_requests <= stall_requests + 1;
    merge_one_run(SORTED_WIDE);
  endtask

  task automatic test_random_runs();
    int unsigned r;
    value_mode_t mode;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        r = $urandom_range(0, 9);
        if (r == 0) write_cfg(4'd0);
        else if (r == 1) write_cfg(CFG_W'($urandom_range(9, 15)));
        else if (r == 2) write_cfg(4'd8);
        else if (r == 3) write_cfg(4'd1);
        else write_cfg(CFG_W'($urandom_range(2, 8)));
      end
      if ($urandom_range(0, 9) == 0) stall_requests <= stall_requests + 1;
      r = $urandom_range(0, 9);
      mode = (r < 5) ? SORTED_WIDE : (r < 8) ? TIE_HEAVY : UNSORTED;
      merge_one_run(mode);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_stream();
    test_mid_load_shrink();
    test_tie_order();
    test_output_backpressure();
    test_random_runs();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stall modes, plus a long hold-off on request.
  initial begin : receiver
    int unsigned stalls_served;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    stalls_served = 0;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_served) begin
        stalls_served = stall_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: begin
            result_ready <= 1'b1;
          end
          1: begin
            result_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            result_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            result_ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    merge_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction value=%0d stream=%0d done=%0b",
                                merged_value, source_stream, merge_done));
      end else begin
        want = expected_q.pop_front();
        if (merged_value !== want.value)
          flag_mismatch($sformatf("merged_value expected %0d got %0d",
                                  $signed(want.value), merged_value));
        if (source_stream !== want.stream)
          flag_mismatch($sformatf("source_stream expected %0d got %0d",
                                  want.stream, source_stream));
        if (has_value !== want.has_value)
          flag_mismatch($sformatf("has_value expected %0b got %0b", want.has_value, has_value));
        if (merge_done !== want.done)
          flag_mismatch($sformatf("merge_done expected %0b got %0b", want.done, merge_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
